[rtl/ipsm_pkg.sv]
package ipsm_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int PIXEL_BITS_DEF = 16;

    // diagonal weight 1/sqrt2 in q16
    localparam int unsigned DIAG_WEIGHT_Q16 = 46341;

    localparam int WIDTH_CFG_BITS  = 13;
    localparam int HEIGHT_CFG_BITS = 16;
    localparam int SUM_BITS        = 64;
    localparam int TALLY_BITS      = 32;
    localparam int DIV_CNT_BITS    = 6;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic rd;        // capture pixel, read line stores
        logic shift;     // shift window, write stores, step counters
        logic mul;       // difference sums and diagonal product
        logic add;       // accumulate
        logic div_init;  // load divider
        logic div_step;  // one quotient bit
        logic out_load;  // load result register, clear frame totals
    } t_cmd;

    typedef struct packed {
        logic frame_end;
        logic div_last;
        logic out_busy;
    } t_status;

endpackage

[rtl/ipsm_ctrl.sv]
module ipsm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ipsm_pkg::t_status i_status,
    output ipsm_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.shift = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = i_status.frame_end ? S_DINIT : S_IDLE;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/ipsm_dp.sv]
module ipsm_dp #(
    parameter int MAX_WIDTH  = ipsm_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = ipsm_pkg::PIXEL_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ipsm_pkg::t_cmd                        i_cmd,
    output ipsm_pkg::t_status                     o_status,
    input  logic [15:0]                           i_pixel,
    input  logic [ipsm_pkg::WIDTH_CFG_BITS-1:0]   i_width,
    input  logic [ipsm_pkg::HEIGHT_CFG_BITS-1:0]  i_height,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [31:0]                           o_mean,
    output logic [31:0]                           o_count,
    output logic                                  o_flag
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PB = PIXEL_BITS;
    localparam int EW = PB + 2;
    localparam int PW = EW + 16;
    localparam int DW = ipsm_pkg::TALLY_BITS + 3;
    localparam int RW = DW + 1;
    localparam int SW = ipsm_pkg::SUM_BITS;
    localparam int HB = ipsm_pkg::HEIGHT_CFG_BITS;

    logic [PB-1:0] upper_mem  [MAX_WIDTH];
    logic [PB-1:0] middle_mem [MAX_WIDTH];

    logic [AW-1:0] r_col;
    logic [HB-1:0] r_row;
    logic [PB-1:0] r_pix, r_up, r_mid;
    logic [PB-1:0] r_win [9];
    logic          r_cnt_en, r_fend;
    logic [EW-1:0] r_edge;
    logic [PW-1:0] r_prod;
    logic [SW-1:0] r_sum;
    logic [ipsm_pkg::TALLY_BITS-1:0] r_tally;
    logic [RW-1:0] r_rem;
    logic [SW-1:0] r_quo;
    logic [DW-1:0] r_div;
    logic [ipsm_pkg::DIV_CNT_BITS-1:0] r_dcnt;
    logic          r_valid;
    logic [31:0]   r_mean, r_count;
    logic          r_flag;

    // effective geometry
    logic [31:0]   width_ext;
    logic [WW-1:0] weff;
    logic [HB-1:0] heff;
    logic          col_last, row_last;

    always_comb begin
        width_ext = 32'(i_width);
        if (width_ext < 32'd3) begin
            weff = WW'(3);
        end else if (width_ext > 32'(MAX_WIDTH)) begin
            weff = WW'(MAX_WIDTH);
        end else begin
            weff = width_ext[WW-1:0];
        end
        heff     = (i_height < HB'(3)) ? HB'(3) : i_height;
        col_last = (WW'(r_col) >= (weff - WW'(1)));
        row_last = (r_row >= (heff - HB'(1)));
    end

    // line stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_up  <= upper_mem[r_col];
            r_mid <= middle_mem[r_col];
            r_pix <= i_pixel[PB-1:0];
        end
        if (i_cmd.shift) begin
            upper_mem[r_col]  <= r_mid;
            middle_mem[r_col] <= r_pix;
        end
    end

    // absolute differences against the center
    function automatic logic [PB-1:0] absdiff(input logic [PB-1:0] a, input logic [PB-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    logic [EW-1:0] edge_sum, diag_sum;
    always_comb begin
        edge_sum = EW'(absdiff(r_win[1], r_win[4])) + EW'(absdiff(r_win[3], r_win[4]))
                 + EW'(absdiff(r_win[5], r_win[4])) + EW'(absdiff(r_win[7], r_win[4]));
        diag_sum = EW'(absdiff(r_win[0], r_win[4])) + EW'(absdiff(r_win[2], r_win[4]))
                 + EW'(absdiff(r_win[6], r_win[4])) + EW'(absdiff(r_win[8], r_win[4]));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_edge <= edge_sum;
            r_prod <= PW'(diag_sum) * PW'(ipsm_pkg::DIAG_WEIGHT_Q16);
        end
    end

    // divider trial
    logic [RW-1:0] trial;
    logic          q_bit;
    always_comb begin
        trial = {r_rem[RW-2:0], r_quo[SW-1]};
        q_bit = (trial >= RW'(r_div));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= r_sum;
            r_div <= {r_tally, 3'b000};
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? (trial - RW'(r_div)) : trial;
            r_quo <= {r_quo[SW-2:0], q_bit};
        end
        if (i_cmd.out_load) begin
            r_mean  <= (r_tally == '0) ? 32'd0 : r_quo[31:0];
            r_count <= r_tally;
            r_flag  <= (r_tally == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_cnt_en <= 1'b0;
            r_fend   <= 1'b0;
            r_sum    <= '0;
            r_tally  <= '0;
            r_dcnt   <= '0;
            r_valid  <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cmd.shift) begin
                r_win[0] <= r_win[1];
                r_win[1] <= r_win[2];
                r_win[2] <= r_up;
                r_win[3] <= r_win[4];
                r_win[4] <= r_win[5];
                r_win[5] <= r_mid;
                r_win[6] <= r_win[7];
                r_win[7] <= r_win[8];
                r_win[8] <= r_pix;
                r_cnt_en <= (r_row >= HB'(2)) && (r_col >= AW'(2)) && (r_win[5] != '0);
                r_fend   <= col_last && row_last;
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : (r_row + HB'(1));
                end else begin
                    r_col <= r_col + AW'(1);
                end
            end
            if (i_cmd.add && r_cnt_en) begin
                r_sum   <= r_sum + (SW'(r_edge) << 16) + SW'(r_prod);
                r_tally <= r_tally + ipsm_pkg::TALLY_BITS'(1);
            end
            if (i_cmd.div_init) begin
                r_dcnt <= '0;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt + ipsm_pkg::DIV_CNT_BITS'(1);
            end
            if (i_cmd.out_load) begin
                r_sum   <= '0;
                r_tally <= '0;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_status.frame_end = r_fend;
    assign o_status.div_last  = &r_dcnt;
    assign o_status.out_busy  = r_valid;
    assign o_valid = r_valid;
    assign o_mean  = r_mean;
    assign o_count = r_count;
    assign o_flag  = r_flag;

endmodule

[rtl/image_point_sharpness_meter_unit.sv]
// point sharpness meter: takes a raster stream of pixels, one band per frame,
// and after the last pixel of each frame emits the mean of the absolute
// differences between every interior nonzero pixel and its 8 neighbours
// (diagonals weighted by 1/sqrt2) in q16, with the pixel count and an
// empty flag. each pixel beat goes through accept, store read/window shift,
// difference and weight multiply and accumulate before the next is taken;
// at the end of a frame a bit-serial divider runs before the result beat is
// loaded. the result sits in an output register, so the next frame's pixels
// are taken while it waits. frame_width and frame_height (apb byte addresses
// 0 and 4) must be written only while the block is idle; the block does not
// enforce this. a width outside 3..MAX_WIDTH or a height below 3 is clamped.
module image_point_sharpness_meter_unit #(
    parameter int MAX_WIDTH  = ipsm_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = ipsm_pkg::PIXEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pixel_value
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] clarity_mean_q16, [63:32] counted_pixels
    output logic        m_axis_tuser    // [0] no_pixels_flag
);

    logic [ipsm_pkg::WIDTH_CFG_BITS-1:0]  r_width;
    logic [ipsm_pkg::HEIGHT_CFG_BITS-1:0] r_height;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ipsm_pkg::WIDTH_CFG_BITS'(4096);
            r_height <= ipsm_pkg::HEIGHT_CFG_BITS'(4096);
        end else if (cfg_wr) begin
            unique case (paddr[2])
                ipsm_pkg::REG_WIDTH:  r_width  <= pwdata[ipsm_pkg::WIDTH_CFG_BITS-1:0];
                ipsm_pkg::REG_HEIGHT: r_height <= pwdata[ipsm_pkg::HEIGHT_CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[2])
            ipsm_pkg::REG_WIDTH:  prdata = 32'(r_width);
            ipsm_pkg::REG_HEIGHT: prdata = 32'(r_height);
            default:              prdata = 32'd0;
        endcase
    end

    ipsm_pkg::t_cmd    cmd;
    ipsm_pkg::t_status status;
    logic [31:0] mean, count;
    logic        flag;

    ipsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ipsm_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_pixel  (s_axis_tdata),
        .i_width  (r_width),
        .i_height (r_height),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_mean   (mean),
        .o_count  (count),
        .o_flag   (flag)
    );

    assign m_axis_tdata = {count, mean};
    assign m_axis_tuser = flag;

endmodule
